// ----- design/rabs_pkg.sv -----
package rabs_pkg;

  // array geometry
  localparam int unsigned Depth     = 1024;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned KeyBits   = 32;

  // item codes
  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeSearch = 1'b1;

  // write request into the element store
  typedef struct packed {
    logic                 we;
    logic [IdxW-1:0]      addr;
    logic [ValueBits-1:0] data;
  } wr_req_t;

  // two read addresses into the element store
  typedef struct packed {
    logic [IdxW-1:0] addr0;
    logic [IdxW-1:0] addr1;
  } rd_req_t;

endpackage

// ----- design/rabs_store.sv -----
module rabs_store (
  input  logic                              clk_i,
  input  rabs_pkg::wr_req_t                 wr_i,
  input  rabs_pkg::rd_req_t                 rd_i,
  output logic [rabs_pkg::ValueBits-1:0]    rd_data0_o,
  output logic [rabs_pkg::ValueBits-1:0]    rd_data1_o
);
  import rabs_pkg::*;

  logic [ValueBits-1:0] mem_q [Depth];

  // one write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rd_data0_o <= mem_q[rd_i.addr0];
    rd_data1_o <= mem_q[rd_i.addr1];
  end

endmodule

// ----- design/rabs_ctrl.sv -----
module rabs_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode_i,
  input  logic [rabs_pkg::IdxW-1:0]         element_index_i,
  input  logic signed [rabs_pkg::ValueBits-1:0] element_value_i,
  input  logic signed [rabs_pkg::KeyBits-1:0]   search_key_i,
  input  logic [rabs_pkg::CntW-1:0]         element_count_i,
  output rabs_pkg::wr_req_t                 wr_o,
  output rabs_pkg::rd_req_t                 rd_o,
  input  logic [rabs_pkg::ValueBits-1:0]    rd_data0_i,
  input  logic [rabs_pkg::ValueBits-1:0]    rd_data1_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic [rabs_pkg::IdxW-1:0]         found_index_o
);
  import rabs_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StFetchHi,
    StDecide
  } state_e;

  state_e                      state_q;
  logic [CntW-1:0]             lo_q;
  logic [CntW-1:0]             end_q;   // one past the last index of the window
  logic [IdxW-1:0]             mid_q;
  logic signed [KeyBits-1:0]   key_q;
  logic signed [ValueBits-1:0] vm_q;
  logic signed [ValueBits-1:0] vl_q;

  logic                        accept;
  logic [CntW-1:0]             cnt_clip;
  logic [CntW-1:0]             span;
  logic [CntW-1:0]             mid_full;
  logic [CntW-1:0]             hi_full;
  logic signed [ValueBits-1:0] vr;
  logic                        hit;
  logic                        go_left;
  logic [CntW-1:0]             mid_ext;

  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q != StIdle);

  // count above the store depth acts as the depth
  assign cnt_clip = (element_count_i > CntW'(Depth)) ? CntW'(Depth) : element_count_i;

  // window midpoint, hi index of the window
  assign span     = end_q - lo_q - CntW'(1);
  assign mid_full = lo_q + (span >> 1);
  assign hi_full  = end_q - CntW'(1);
  assign mid_ext  = {1'b0, mid_q};

  // load transfer writes the store directly
  assign wr_o.we   = accept && (mode_i == ModeLoad);
  assign wr_o.addr = element_index_i;
  assign wr_o.data = element_value_i;

  // port 0 reads mid then hi, port 1 reads lo
  always_comb begin
    rd_o.addr0 = mid_full[IdxW-1:0];
    if (state_q == StFetchHi) begin
      rd_o.addr0 = hi_full[IdxW-1:0];
    end
    rd_o.addr1 = lo_q[IdxW-1:0];
  end

  // probe decision: which half can still hold the key
  assign vr  = rd_data0_i;
  assign hit = (vm_q == key_q);
  always_comb begin
    if (vm_q >= vl_q) begin
      go_left = (vl_q <= key_q) && (key_q < vm_q);
    end else begin
      go_left = !((vm_q < key_q) && (key_q <= vr));
    end
  end

  // sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      done_o        <= 1'b0;
      found_o       <= 1'b0;
      found_index_o <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept && (mode_i == ModeSearch)) begin
            key_q   <= search_key_i;
            lo_q    <= '0;
            end_q   <= cnt_clip;
            state_q <= StCheck;
          end
        end
        StCheck: begin
          if (lo_q < end_q) begin
            mid_q   <= mid_full[IdxW-1:0];
            state_q <= StFetchHi;
          end else begin
            done_o        <= 1'b1;
            found_o       <= 1'b0;
            found_index_o <= '0;
            state_q       <= StIdle;
          end
        end
        StFetchHi: begin
          vm_q    <= rd_data0_i;
          vl_q    <= rd_data1_i;
          state_q <= StDecide;
        end
        StDecide: begin
          if (hit) begin
            done_o        <= 1'b1;
            found_o       <= 1'b1;
            found_index_o <= mid_q;
            state_q       <= StIdle;
          end else begin
            if (go_left) begin
              end_q <= mid_ext;
            end else begin
              lo_q <= mid_ext + CntW'(1);
            end
            state_q <= StCheck;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ----- design/rotated_array_binary_search_core.sv -----
// Searches a rotated ascending array of signed 32-bit values held in a
// 1024-entry store. A transfer with mode 0 writes one element in the same
// clock and gives no result; busy stays low. A transfer with mode 1 runs a
// binary search over the first element_count entries (counts above 1024 act
// as 1024) and raises done_o for exactly one cycle with found_o and
// found_index_o; the receiver cannot stall, so the result must be taken in
// that cycle. Each probe reads mid and lo on the two store ports, then reads
// hi, then compares. start is ignored while busy is high. element_count must
// be written through element_count_we_i only while idle; the block itself
// does not enforce this. Store entries are not cleared at reset and must be
// loaded before they are searched.
module rotated_array_binary_search_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  mode_i,
  input  logic [rabs_pkg::IdxW-1:0]             element_index_i,
  input  logic signed [rabs_pkg::ValueBits-1:0] element_value_i,
  input  logic signed [rabs_pkg::KeyBits-1:0]   search_key_i,
  input  logic                                  element_count_we_i,
  input  logic [rabs_pkg::CntW-1:0]             element_count_i,
  output logic                                  done_o,
  output logic                                  found_o,
  output logic [rabs_pkg::IdxW-1:0]             found_index_o
);
  import rabs_pkg::*;

  logic [CntW-1:0]      element_count_q;
  wr_req_t              wr;
  rd_req_t              rd;
  logic [ValueBits-1:0] rd_data0;
  logic [ValueBits-1:0] rd_data1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= '0;
    end else if (element_count_we_i) begin
      element_count_q <= element_count_i;
    end
  end

  // search sequencer with shared compare unit
  rabs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .search_key_i    (search_key_i),
    .element_count_i (element_count_q),
    .wr_o            (wr),
    .rd_o            (rd),
    .rd_data0_i      (rd_data0),
    .rd_data1_i      (rd_data1),
    .done_o          (done_o),
    .found_o         (found_o),
    .found_index_o   (found_index_o)
  );

  // element store
  rabs_store u_store (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_i       (rd),
    .rd_data0_o (rd_data0),
    .rd_data1_o (rd_data1)
  );

endmodule
